// ===== design/graph_automorphism_counter_core_macros.svh =====
// assertion macros used by the checker file
`ifndef GRAPH_AUTOMORPHISM_COUNTER_CORE_MACROS_SVH
`define GRAPH_AUTOMORPHISM_COUNTER_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define GAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define GAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gac_pkg.sv =====
// shared widths and defaults for the graph automorphism counter
package gac_pkg;
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 8;
  localparam int ROWCOL_W         = 4;
  localparam int WEIGHT_W         = 8;
  localparam int COUNT_W          = 45;
  localparam int CLASS_W          = 5;
  localparam int VCOUNT_W         = 5;
  localparam int VCOUNT_RESET     = 16;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  // register select is paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;
endpackage

// ===== design/gac_ram.sv =====
// generic ram: one write port, two registered read ports
module gac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0 <= mem_r[raddr0];
    rdata1 <= mem_r[raddr1];
  end
endmodule

// ===== design/graph_automorphism_counter_core.sv =====
// graph automorphism counter: top level
//
// Input channel (in_valid / in_stall): one adjacency entry per item, row,
// col, weight and last; entries are taken one per cycle while idle. An
// entry with last set starts refinement and the search; in_stall stays high
// until the result has been loaded into the output register and the store
// cleared again.
// Result channel (out_valid / out_stall): automorphism count, non-identity
// count and colour class count. The result sits in an output register and
// holds while out_stall is high; loading of the next graph may go on.
// Latency after the last item is data dependent: each refinement round
// compares vertex pairs through the two read ports of the adjacency ram,
// and the search tests each candidate through the same two ports.
// Reset, and each finished result, start a clearing pass over all
// 2^(2*clog2(MAX_VERTICES)) adjacency entries (256 by default) with
// in_stall high. vertex_count is written over the cfg_ port; it is to be
// written only while the block is idle, which the block does not enforce.
module graph_automorphism_counter_core
  import gac_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ROWCOL_W-1:0]   in_row,
  input  logic [ROWCOL_W-1:0]   in_col,
  input  logic [WEIGHT_W-1:0]   in_weight,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    out_automorphism_count,
  output logic [COUNT_W-1:0]    out_nonidentity_count,
  output logic [CLASS_W-1:0]    out_color_class_count,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int AW    = 2 * VW;
  localparam int CAW   = VW + 1;
  localparam int IW    = VW + 1;
  localparam int WB    = WEIGHT_BITS;
  localparam int CMPW  = (NW > VCOUNT_W) ? NW : VCOUNT_W;
  localparam int RCW   = (NW > ROWCOL_W) ? NW : ROWCOL_W;
  localparam int ADJ_DEPTH = 1 << AW;
  localparam int COL_DEPTH = 1 << CAW;

  typedef enum logic [28:0] {
    ST_CLEAR  = 29'd1 << 0,
    ST_IDLE   = 29'd1 << 1,
    ST_RINIT  = 29'd1 << 2,
    ST_RU     = 29'd1 << 3,
    ST_RUW    = 29'd1 << 4,
    ST_RV     = 29'd1 << 5,
    ST_RVW    = 29'd1 << 6,
    ST_RKEY   = 29'd1 << 7,
    ST_RKEYW  = 29'd1 << 8,
    ST_RSW    = 29'd1 << 9,
    ST_RSWD   = 29'd1 << 10,
    ST_REV    = 29'd1 << 11,
    ST_RNRD   = 29'd1 << 12,
    ST_RNWR   = 29'd1 << 13,
    ST_RNEW   = 29'd1 << 14,
    ST_RDONE  = 29'd1 << 15,
    ST_CRD    = 29'd1 << 16,
    ST_CDR    = 29'd1 << 17,
    ST_ORD    = 29'd1 << 18,
    ST_ODR    = 29'd1 << 19,
    ST_STRY   = 29'd1 << 20,
    ST_SCOL   = 29'd1 << 21,
    ST_SFITO  = 29'd1 << 22,
    ST_SFITI  = 29'd1 << 23,
    ST_SFITD  = 29'd1 << 24,
    ST_SBACK  = 29'd1 << 25,
    ST_SSUCC  = 29'd1 << 26,
    ST_SMUL   = 29'd1 << 27,
    ST_DONE   = 29'd1 << 28
  } state_t;

  state_t state_r, state_nxt;

  logic [VCOUNT_W-1:0] vc_r, vc_nxt;
  logic [NW-1:0]       nv;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]  out_total_r, out_total_nxt;
  logic [CLASS_W-1:0]  out_class_r, out_class_nxt;

  // refinement
  logic                bank_r, bank_nxt;
  logic [VW-1:0]       u_r, u_nxt, v_r, v_nxt, x_r, x_nxt, y_r, y_nxt;
  logic                dir_r, dir_nxt;
  logic [VW-1:0]       cu_r, cu_nxt, ref_c_r, ref_c_nxt;
  logic [WB-1:0]       ref_w_r, ref_w_nxt;
  logic [NW-1:0]       cnt_u_r, cnt_u_nxt, cnt_v_r, cnt_v_nxt;
  logic [NW-1:0]       nz_u_r, nz_u_nxt, nz_v_r, nz_v_nxt;
  logic [NW-1:0]       classes_r, classes_nxt;
  logic                changed_r, changed_nxt;
  logic                sw_pend_r, sw_pend_nxt;

  // visit order
  logic [NW-1:0]       csize_r [MAX_VERTICES];
  logic [NW-1:0]       csize_nxt [MAX_VERTICES];
  logic [VW-1:0]       order_r [MAX_VERTICES];
  logic [VW-1:0]       order_nxt [MAX_VERTICES];
  logic [NW-1:0]       s_r, s_nxt, ps_r, ps_nxt;
  logic [VW-1:0]       pv_r, pv_nxt, len_r, len_nxt;
  logic                cs_pend_r, cs_pend_nxt, ord_pend_r, ord_pend_nxt;

  // search
  logic [IW-1:0]       image_r [MAX_VERTICES];
  logic [IW-1:0]       image_nxt [MAX_VERTICES];
  logic                used_r [MAX_VERTICES];
  logic                used_nxt [MAX_VERTICES];
  logic [NW-1:0]       cursor_r [MAX_VERTICES];
  logic [NW-1:0]       cursor_nxt [MAX_VERTICES];
  logic [VW-1:0]       d0_r, d0_nxt, d_r, d_nxt, w_r, w_nxt;
  logic [NW-1:0]       orbit_r, orbit_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic                fail_r, fail_nxt, fit_pend_r, fit_pend_nxt;

  logic [VW-1:0]       uvtx, cand_v, iw;
  logic [NW-1:0]       cand;
  logic                fit_bad, sig_bad, cfg_wr;

  // memory ports
  logic                adj_we;
  logic [AW-1:0]       adj_waddr, adj_ra0, adj_ra1;
  logic [WB-1:0]       adj_wdata, adj_rd0, adj_rd1;
  logic                col_we;
  logic [CAW-1:0]      col_waddr, col_ra0, col_ra1;
  logic [VW-1:0]       col_wdata, col_rd0, col_rd1;

  function automatic logic is_last(input logic [VW-1:0] i, input logic [NW-1:0] n);
    return (NW'(i) + NW'(1)) == n;
  endfunction

  gac_ram #(.WIDTH(WB), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk    (clk),
    .we     (adj_we),
    .waddr  (adj_waddr),
    .wdata  (adj_wdata),
    .raddr0 (adj_ra0),
    .rdata0 (adj_rd0),
    .raddr1 (adj_ra1),
    .rdata1 (adj_rd1)
  );

  // two colour banks: current and next round
  gac_ram #(.WIDTH(VW), .DEPTH(COL_DEPTH)) u_col_ram (
    .clk    (clk),
    .we     (col_we),
    .waddr  (col_waddr),
    .wdata  (col_wdata),
    .raddr0 (col_ra0),
    .rdata0 (col_rd0),
    .raddr1 (col_ra1),
    .rdata1 (col_rd1)
  );

  always_comb begin
    if (vc_r == '0) begin
      nv = NW'(1);
    end else if (CMPW'(vc_r) > CMPW'(MAX_VERTICES)) begin
      nv = NW'(MAX_VERTICES);
    end else begin
      nv = NW'(vc_r);
    end
  end

  assign uvtx    = order_r[d_r];
  assign cand    = cursor_r[d_r];
  assign cand_v  = cand[VW-1:0];
  assign iw      = image_r[w_r][VW-1:0];
  assign fit_bad = fail_r | (fit_pend_r && (adj_rd0 != adj_rd1));
  assign sig_bad = ((ref_w_r != '0) && (cnt_u_r != cnt_v_r)) ||
                   ((x_r == '0) && (nz_u_r != nz_v_r));
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_VERTEX_COUNT);

  assign in_stall               = (state_r != ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_automorphism_count = out_total_r;
  assign out_nonidentity_count  = out_total_r - COUNT_W'(1);
  assign out_color_class_count  = out_class_r;
  assign cfg_pready             = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_VERTEX_COUNT) ? CFG_DATA_W'(vc_r) : '0;

  always_comb begin
    state_nxt = state_r;     vc_nxt = vc_r;         clr_nxt = clr_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r; out_class_nxt = out_class_r;
    bank_nxt = bank_r;  u_nxt = u_r;  v_nxt = v_r;  x_nxt = x_r;  y_nxt = y_r;
    dir_nxt = dir_r;    cu_nxt = cu_r; ref_c_nxt = ref_c_r; ref_w_nxt = ref_w_r;
    cnt_u_nxt = cnt_u_r; cnt_v_nxt = cnt_v_r; nz_u_nxt = nz_u_r; nz_v_nxt = nz_v_r;
    classes_nxt = classes_r; changed_nxt = changed_r;
    csize_nxt = csize_r; order_nxt = order_r;
    s_nxt = s_r; ps_nxt = ps_r; pv_nxt = pv_r; len_nxt = len_r;
    image_nxt = image_r; used_nxt = used_r; cursor_nxt = cursor_r;
    d0_nxt = d0_r; d_nxt = d_r; w_nxt = w_r; orbit_nxt = orbit_r;
    total_nxt = total_r; fail_nxt = fail_r;
    sw_pend_nxt = 1'b0; cs_pend_nxt = 1'b0; ord_pend_nxt = 1'b0; fit_pend_nxt = 1'b0;
    adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_ra0 = '0; adj_ra1 = '0;
    col_we = 1'b0; col_waddr = '0; col_wdata = '0; col_ra0 = '0; col_ra1 = '0;

    if (cfg_wr) begin
      vc_nxt = cfg_pwdata[VCOUNT_W-1:0];
    end

    // read data from the previous cycle
    if (sw_pend_r) begin
      if ((adj_rd0 == ref_w_r) && (col_rd0 == ref_c_r)) cnt_u_nxt = cnt_u_r + NW'(1);
      if ((adj_rd1 == ref_w_r) && (col_rd0 == ref_c_r)) cnt_v_nxt = cnt_v_r + NW'(1);
      if (x_r == '0) begin
        if (adj_rd0 != '0) nz_u_nxt = nz_u_r + NW'(1);
        if (adj_rd1 != '0) nz_v_nxt = nz_v_r + NW'(1);
      end
    end
    if (fit_pend_r && (adj_rd0 != adj_rd1)) fail_nxt = 1'b1;
    if (cs_pend_r) csize_nxt[col_rd0] = csize_r[col_rd0] + NW'(1);
    if (ord_pend_r && (csize_r[col_rd0] == ps_r)) begin
      order_nxt[len_r] = pv_r;
      len_nxt = len_r + VW'(1);
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if ((RCW'(in_row) < RCW'(MAX_VERTICES)) && (RCW'(in_col) < RCW'(MAX_VERTICES))) begin
            adj_we    = 1'b1;
            adj_waddr = {VW'(in_row), VW'(in_col)};
            adj_wdata = WB'(in_weight);
          end
          if (in_last) begin
            u_nxt     = '0;
            bank_nxt  = 1'b0;
            state_nxt = ST_RINIT;
          end
        end
      end
      ST_RINIT: begin
        col_we    = 1'b1;
        col_waddr = {bank_r, u_r};
        if (is_last(u_r, nv)) begin
          u_nxt = '0; classes_nxt = '0; changed_nxt = 1'b0;
          state_nxt = ST_RU;
        end else begin
          u_nxt = u_r + VW'(1);
        end
      end
      ST_RU: begin
        col_ra0   = {bank_r, u_r};
        state_nxt = ST_RUW;
      end
      ST_RUW: begin
        cu_nxt    = col_rd0;
        v_nxt     = '0;
        state_nxt = (u_r == '0) ? ST_RNEW : ST_RV;
      end
      ST_RV: begin
        col_ra0   = {bank_r, v_r};
        state_nxt = ST_RVW;
      end
      ST_RVW: begin
        if (col_rd0 != cu_r) begin
          if (v_r + VW'(1) == u_r) state_nxt = ST_RNEW;
          else begin
            v_nxt = v_r + VW'(1);
            state_nxt = ST_RV;
          end
        end else begin
          dir_nxt = 1'b0; x_nxt = '0;
          state_nxt = ST_RKEY;
        end
      end
      ST_RKEY: begin
        adj_ra0   = dir_r ? {x_r, u_r} : {u_r, x_r};
        col_ra0   = {bank_r, x_r};
        state_nxt = ST_RKEYW;
      end
      ST_RKEYW: begin
        ref_w_nxt = adj_rd0; ref_c_nxt = col_rd0;
        y_nxt = '0; cnt_u_nxt = '0; cnt_v_nxt = '0;
        if (x_r == '0) begin
          nz_u_nxt = '0; nz_v_nxt = '0;
        end
        state_nxt = ST_RSW;
      end
      ST_RSW: begin
        adj_ra0     = dir_r ? {y_r, u_r} : {u_r, y_r};
        adj_ra1     = dir_r ? {y_r, v_r} : {v_r, y_r};
        col_ra0     = {bank_r, y_r};
        sw_pend_nxt = 1'b1;
        if (is_last(y_r, nv)) state_nxt = ST_RSWD;
        else y_nxt = y_r + VW'(1);
      end
      ST_RSWD: begin
        state_nxt = ST_REV;
      end
      ST_REV: begin
        if (sig_bad) begin
          if (v_r + VW'(1) == u_r) state_nxt = ST_RNEW;
          else begin
            v_nxt = v_r + VW'(1);
            state_nxt = ST_RV;
          end
        end else if (is_last(x_r, nv)) begin
          if (!dir_r) begin
            dir_nxt = 1'b1; x_nxt = '0;
            state_nxt = ST_RKEY;
          end else begin
            state_nxt = ST_RNRD;
          end
        end else begin
          x_nxt = x_r + VW'(1);
          state_nxt = ST_RKEY;
        end
      end
      ST_RNRD: begin
        col_ra0   = {!bank_r, v_r};
        state_nxt = ST_RNWR;
      end
      ST_RNWR: begin
        col_we    = 1'b1;
        col_waddr = {!bank_r, u_r};
        col_wdata = col_rd0;
        if (col_rd0 != cu_r) changed_nxt = 1'b1;
        if (is_last(u_r, nv)) state_nxt = ST_RDONE;
        else begin
          u_nxt = u_r + VW'(1);
          state_nxt = ST_RU;
        end
      end
      ST_RNEW: begin
        col_we      = 1'b1;
        col_waddr   = {!bank_r, u_r};
        col_wdata   = classes_r[VW-1:0];
        classes_nxt = classes_r + NW'(1);
        if (classes_r[VW-1:0] != cu_r) changed_nxt = 1'b1;
        if (is_last(u_r, nv)) state_nxt = ST_RDONE;
        else begin
          u_nxt = u_r + VW'(1);
          state_nxt = ST_RU;
        end
      end
      ST_RDONE: begin
        if (changed_r) begin
          bank_nxt = !bank_r; u_nxt = '0; classes_nxt = '0; changed_nxt = 1'b0;
          state_nxt = ST_RU;
        end else begin
          for (int i = 0; i < MAX_VERTICES; i++) csize_nxt[i] = '0;
          v_nxt = '0;
          state_nxt = ST_CRD;
        end
      end
      ST_CRD: begin
        col_ra0     = {bank_r, v_r};
        cs_pend_nxt = 1'b1;
        if (is_last(v_r, nv)) state_nxt = ST_CDR;
        else v_nxt = v_r + VW'(1);
      end
      ST_CDR: begin
        s_nxt = NW'(1); v_nxt = '0; len_nxt = '0;
        state_nxt = ST_ORD;
      end
      ST_ORD: begin
        // stable order: by class size, then by vertex number
        col_ra0      = {bank_r, v_r};
        ord_pend_nxt = 1'b1;
        pv_nxt       = v_r;
        ps_nxt       = s_r;
        if (is_last(v_r, nv)) begin
          v_nxt = '0;
          if (s_r == nv) state_nxt = ST_ODR;
          else s_nxt = s_r + NW'(1);
        end else begin
          v_nxt = v_r + VW'(1);
        end
      end
      ST_ODR: begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          image_nxt[i] = {1'b1, VW'(0)};
          used_nxt[i]  = 1'b0;
        end
        total_nxt = COUNT_W'(1);
        d0_nxt = '0; d_nxt = '0; cursor_nxt[0] = '0; orbit_nxt = '0;
        state_nxt = ST_STRY;
      end
      ST_STRY: begin
        if (cand == nv) begin
          if (d_r == d0_r) state_nxt = ST_SMUL;
          else begin
            d_nxt = d_r - VW'(1);
            state_nxt = ST_SBACK;
          end
        end else begin
          col_ra0   = {bank_r, uvtx};
          col_ra1   = {bank_r, cand_v};
          state_nxt = ST_SCOL;
        end
      end
      ST_SCOL: begin
        if ((col_rd0 != col_rd1) || used_r[cand_v]) begin
          cursor_nxt[d_r] = cand + NW'(1);
          state_nxt = ST_STRY;
        end else begin
          adj_ra0 = {uvtx, uvtx};
          adj_ra1 = {cand_v, cand_v};
          fit_pend_nxt = 1'b1;
          fail_nxt = 1'b0;
          w_nxt = '0;
          state_nxt = ST_SFITO;
        end
      end
      ST_SFITO: begin
        if (!image_r[w_r][VW]) begin
          adj_ra0 = {uvtx, w_r};
          adj_ra1 = {cand_v, iw};
          fit_pend_nxt = 1'b1;
        end
        state_nxt = ST_SFITI;
      end
      ST_SFITI: begin
        if (!image_r[w_r][VW]) begin
          adj_ra0 = {w_r, uvtx};
          adj_ra1 = {iw, cand_v};
          fit_pend_nxt = 1'b1;
        end
        if (is_last(w_r, nv)) state_nxt = ST_SFITD;
        else begin
          w_nxt = w_r + VW'(1);
          state_nxt = ST_SFITO;
        end
      end
      ST_SFITD: begin
        if (fit_bad) begin
          cursor_nxt[d_r] = cand + NW'(1);
          state_nxt = ST_STRY;
        end else begin
          image_nxt[uvtx] = {1'b0, cand_v};
          used_nxt[cand_v] = 1'b1;
          if (is_last(d_r, nv)) state_nxt = ST_SSUCC;
          else begin
            cursor_nxt[d_r + VW'(1)] = '0;
            d_nxt = d_r + VW'(1);
            state_nxt = ST_STRY;
          end
        end
      end
      ST_SBACK: begin
        image_nxt[uvtx]  = {1'b1, VW'(0)};
        used_nxt[cand_v] = 1'b0;
        cursor_nxt[d_r]  = cand + NW'(1);
        state_nxt = ST_STRY;
      end
      ST_SSUCC: begin
        // unwind a full mapping back to the stabiliser level
        image_nxt[uvtx]  = {1'b1, VW'(0)};
        used_nxt[cand_v] = 1'b0;
        if (d_r == d0_r) begin
          orbit_nxt = orbit_r + NW'(1);
          cursor_nxt[d_r] = cand + NW'(1);
          state_nxt = ST_STRY;
        end else begin
          d_nxt = d_r - VW'(1);
        end
      end
      ST_SMUL: begin
        total_nxt = COUNT_W'(total_r * COUNT_W'(orbit_r));
        image_nxt[uvtx] = {1'b0, uvtx};
        used_nxt[uvtx]  = 1'b1;
        if (is_last(d0_r, nv)) state_nxt = ST_DONE;
        else begin
          d0_nxt = d0_r + VW'(1);
          d_nxt  = d0_r + VW'(1);
          cursor_nxt[d0_r + VW'(1)] = '0;
          orbit_nxt = '0;
          state_nxt = ST_STRY;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_total_nxt = total_r;
          out_class_nxt = CLASS_W'(classes_r);
          out_valid_nxt = 1'b1;
          clr_nxt = '0;
          state_nxt = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      vc_r        <= VCOUNT_W'(VCOUNT_RESET);
      sw_pend_r   <= 1'b0;
      cs_pend_r   <= 1'b0;
      ord_pend_r  <= 1'b0;
      fit_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      vc_r        <= vc_nxt;
      sw_pend_r   <= sw_pend_nxt;
      cs_pend_r   <= cs_pend_nxt;
      ord_pend_r  <= ord_pend_nxt;
      fit_pend_r  <= fit_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_total_r <= out_total_nxt; out_class_r <= out_class_nxt;
    bank_r <= bank_nxt; u_r <= u_nxt; v_r <= v_nxt; x_r <= x_nxt; y_r <= y_nxt;
    dir_r <= dir_nxt; cu_r <= cu_nxt; ref_c_r <= ref_c_nxt; ref_w_r <= ref_w_nxt;
    cnt_u_r <= cnt_u_nxt; cnt_v_r <= cnt_v_nxt; nz_u_r <= nz_u_nxt; nz_v_r <= nz_v_nxt;
    classes_r <= classes_nxt; changed_r <= changed_nxt;
    csize_r <= csize_nxt; order_r <= order_nxt;
    s_r <= s_nxt; ps_r <= ps_nxt; pv_r <= pv_nxt; len_r <= len_nxt;
    image_r <= image_nxt; used_r <= used_nxt; cursor_r <= cursor_nxt;
    d0_r <= d0_nxt; d_r <= d_nxt; w_r <= w_nxt; orbit_r <= orbit_nxt;
    total_r <= total_nxt; fail_r <= fail_nxt;
  end
endmodule

// ===== design/gac_checker.sv =====
// port-level checker for the graph automorphism counter, bound to the top
`include "graph_automorphism_counter_core_macros.svh"

module gac_checker
  import gac_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COUNT_W-1:0] out_automorphism_count,
  input logic [COUNT_W-1:0] out_nonidentity_count,
  input logic [CLASS_W-1:0] out_color_class_count
);
  `GAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `GAC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_automorphism_count) && $stable(out_color_class_count), "result changed while stalled")
  `GAC_ASSERT_SAME(a_nonid, out_valid, out_nonidentity_count == out_automorphism_count - COUNT_W'(1), "non-identity count mismatch")
  `GAC_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_last, in_stall, "item taken after last entry")
  `GAC_ASSERT_SAME(a_result_busy, $rose(out_valid), $past(in_stall), "result without search")
endmodule

bind graph_automorphism_counter_core gac_checker u_gac_checker (.*);
